/* rtl/bitmap_slot_allocator_macros.svh */
`ifndef BITMAP_SLOT_ALLOCATOR_MACROS_SVH
`define BITMAP_SLOT_ALLOCATOR_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define BSA_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define BSA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/bsa_pkg.sv */
package bsa_pkg;

    localparam int WORD_BITS   = 32;
    localparam int BIT_W       = $clog2(WORD_BITS);
    localparam int SLOT_BYTES  = 16;
    localparam int SLOT_SHIFT  = $clog2(SLOT_BYTES);
    localparam int POOL_W      = 11;
    localparam int POOL_MAX    = (1 << POOL_W) - 1;
    localparam int SIZE_W      = 16;
    localparam int IN_OFF_W    = 16;
    localparam int OFFSET_W    = 14;
    localparam int AVAIL_W     = 15;

    localparam logic [POOL_W-1:0] POOL_RESET = 11'd1024;

    localparam logic [1:0] ACT_ALLOC = 2'd0;
    localparam logic [1:0] ACT_FREE  = 2'd1;
    localparam logic [1:0] ACT_QUERY = 2'd2;

    typedef enum logic [2:0] {
        STS_OK        = 3'd0,
        STS_BAD_SIZE  = 3'd1,
        STS_FULL      = 3'd2,
        STS_RANGE     = 3'd3,
        STS_NOT_ALLOC = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FREE,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [1:0]          action;
        logic [SIZE_W-1:0]   request_size;
        logic [IN_OFF_W-1:0] byte_offset;
    } t_req;

    typedef struct packed {
        t_status             status;
        logic [OFFSET_W-1:0] slot_offset;
        logic [AVAIL_W-1:0]  available_bytes;
    } t_resp;

endpackage

/* rtl/bsa_bitmap_ram.sv */
module bsa_bitmap_ram
    import bsa_pkg::*;
#(
    parameter int DEPTH = 32,
    parameter int AW    = 5
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic [AW-1:0]        i_rd_addr,
    output logic [WORD_BITS-1:0] o_rd_data,
    input  logic                 i_wr_en,
    input  logic [AW-1:0]        i_wr_addr,
    input  logic [WORD_BITS-1:0] i_wr_data
);

    logic [WORD_BITS-1:0] r_mem [DEPTH];
    logic [DEPTH-1:0]     r_valid;
    logic [WORD_BITS-1:0] r_rd_data;
    logic                 r_rd_valid;

    // A word never written since reset reads as all free.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_wr_en) begin
            r_valid[i_wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data  <= r_mem[i_rd_addr];
        r_rd_valid <= r_valid[i_rd_addr];
    end

    assign o_rd_data = r_rd_valid ? r_rd_data : '0;

endmodule

/* rtl/bsa_word_pick.sv */
module bsa_word_pick
    import bsa_pkg::*;
(
    input  logic [WORD_BITS-1:0] i_word,
    input  logic                 i_is_last,
    input  logic [BIT_W-1:0]     i_pool_lo,
    output logic                 o_found,
    output logic [BIT_W-1:0]     o_bit
);

    logic [WORD_BITS-1:0] keep;
    logic [WORD_BITS-1:0] busy;

    // In the last word of the pool, treat slots past the end as taken.
    always_comb begin
        if (i_pool_lo == '0) begin
            keep = '1;
        end else begin
            keep = (WORD_BITS'(1) << i_pool_lo) - WORD_BITS'(1);
        end
        busy = i_is_last ? (i_word | ~keep) : i_word;
    end

    // Lowest zero bit wins.
    always_comb begin
        o_found = 1'b0;
        o_bit   = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (!busy[i]) begin
                o_found = 1'b1;
                o_bit   = BIT_W'(i);
            end
        end
    end

endmodule

/* rtl/bitmap_slot_allocator.sv */
// Slot allocator over a pool of 16-byte slots, one bitmap bit per slot.
// Request channel (i_in_valid/o_in_ready, i_in): allocate, free or query.
// Response channel (o_out_valid/i_out_ready, o_out): one beat per request,
// carrying status, granted byte offset and the free bytes after the request.
// Config channel (i_cfg_valid/o_cfg_ready, i_cfg_pool_slots): pool size in
// slots; always ready, write it only while no request is outstanding.
// Steps from acceptance to response valid:
//   query or rejected request: straight to the done state
//   free: one bitmap word read, then write back
//   allocate: one scan step per bitmap word read until the first word with a
//   free slot in the pool, at most ceil(pool_slots / 32) words, 32 for a
//   1024-slot pool.
//   The bitmap RAM port reads one word a cycle.
// One request is in flight at a time; the next is accepted once the response
// has moved into the output register, even if the receiver has not taken it.
// A stalled receiver holds the response beat and, behind it, at most one
// finished request; the request channel then stays not ready.
// Reset clears the bitmap at once through per-word valid flags (no clearing
// pass), zeroes the allocation count and sets the pool to 1024 slots.
`include "bitmap_slot_allocator_macros.svh"

module bitmap_slot_allocator
    import bsa_pkg::*;
#(
    parameter int MAX_SLOTS = 1024
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  t_req              i_in,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output t_resp             o_out,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [POOL_W-1:0] i_cfg_pool_slots
);

    // The pool register cannot name more than POOL_MAX slots.
    localparam int USE_SLOTS = (MAX_SLOTS < POOL_MAX) ? MAX_SLOTS : POOL_MAX;
    localparam int DEPTH     = (USE_SLOTS + WORD_BITS - 1) / WORD_BITS;
    localparam int AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int FS_W      = IN_OFF_W - SLOT_SHIFT;

    t_state               r_state, n_state;
    logic [AW-1:0]        r_chk, n_chk;
    logic [AW-1:0]        r_last, n_last;
    logic [BIT_W-1:0]     r_bit, n_bit;
    t_status              r_status, n_status;
    logic [OFFSET_W-1:0]  r_slot_off, n_slot_off;
    logic [POOL_W-1:0]    r_count, n_count;
    logic [POOL_W-1:0]    r_pool;
    logic                 r_out_valid;
    t_resp                r_out;

    logic                 in_fire;
    logic                 out_free;
    logic [POOL_W-1:0]    pool_eff;
    logic [POOL_W-1:0]    pool_m1;
    logic [FS_W-1:0]      free_slot;
    logic                 free_ok;
    logic [POOL_W-1:0]    free_cnt;
    logic [AVAIL_W-1:0]   avail;

    logic [AW-1:0]        rd_addr;
    logic [WORD_BITS-1:0] rd_data;
    logic                 mem_we;
    logic [WORD_BITS-1:0] wr_data;
    logic                 pick_found;
    logic [BIT_W-1:0]     pick_bit;
    logic                 chk_last;

    assign o_in_ready  = (r_state == S_IDLE);
    assign in_fire     = i_in_valid && o_in_ready;
    assign out_free    = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;
    assign o_cfg_ready = 1'b1;

    assign pool_eff  = (r_pool > POOL_W'(USE_SLOTS)) ? POOL_W'(USE_SLOTS) : r_pool;
    assign pool_m1   = pool_eff - POOL_W'(1);
    assign free_slot = i_in.byte_offset[IN_OFF_W-1:SLOT_SHIFT];
    assign free_ok   = (i_in.byte_offset[SLOT_SHIFT-1:0] == '0)
                    && (free_slot < FS_W'(pool_eff));
    assign chk_last  = (r_chk == r_last);
    assign free_cnt  = (pool_eff > r_count) ? (pool_eff - r_count) : '0;
    assign avail     = AVAIL_W'({free_cnt, {SLOT_SHIFT{1'b0}}});

    bsa_bitmap_ram #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ram (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data),
        .i_wr_en   (mem_we),
        .i_wr_addr (r_chk),
        .i_wr_data (wr_data)
    );

    bsa_word_pick u_pick (
        .i_word    (rd_data),
        .i_is_last (chk_last),
        .i_pool_lo (pool_eff[BIT_W-1:0]),
        .o_found   (pick_found),
        .o_bit     (pick_bit)
    );

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    if (i_in.action == ACT_ALLOC && i_in.request_size != '0
                            && pool_eff != '0) begin
                        n_state = S_SCAN;
                    end else if (i_in.action == ACT_FREE && free_ok) begin
                        n_state = S_FREE;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_SCAN: begin
                if (pick_found || chk_last) begin
                    n_state = S_DONE;
                end
            end
            S_FREE: n_state = S_DONE;
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Datapath and RAM control.
    always_comb begin
        n_chk      = r_chk;
        n_last     = r_last;
        n_bit      = r_bit;
        n_status   = r_status;
        n_slot_off = r_slot_off;
        n_count    = r_count;
        rd_addr    = r_chk + AW'(1);
        mem_we     = 1'b0;
        wr_data    = rd_data;
        unique case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    n_status   = STS_OK;
                    n_slot_off = '0;
                    if (i_in.action == ACT_ALLOC) begin
                        rd_addr = '0;
                        n_chk   = '0;
                        n_last  = pool_m1[BIT_W +: AW];
                        if (i_in.request_size == '0) begin
                            n_status = STS_BAD_SIZE;
                        end else if (pool_eff == '0) begin
                            n_status = STS_FULL;
                        end
                    end else if (i_in.action == ACT_FREE) begin
                        rd_addr = free_slot[BIT_W +: AW];
                        n_chk   = free_slot[BIT_W +: AW];
                        n_bit   = free_slot[BIT_W-1:0];
                        if (!free_ok) begin
                            n_status = STS_RANGE;
                        end
                    end
                end
            end
            S_SCAN: begin
                n_chk = r_chk + AW'(1);
                if (pick_found) begin
                    n_chk      = r_chk;
                    mem_we     = 1'b1;
                    wr_data    = rd_data | (WORD_BITS'(1) << pick_bit);
                    n_count    = r_count + POOL_W'(1);
                    n_slot_off = OFFSET_W'({r_chk, pick_bit, {SLOT_SHIFT{1'b0}}});
                end else if (chk_last) begin
                    n_status = STS_FULL;
                end
            end
            S_FREE: begin
                if (rd_data[r_bit]) begin
                    mem_we  = 1'b1;
                    wr_data = rd_data & ~(WORD_BITS'(1) << r_bit);
                    if (r_count != '0) begin
                        n_count = r_count - POOL_W'(1);
                    end
                end else begin
                    n_status = STS_NOT_ALLOC;
                end
            end
            S_DONE: begin
                n_chk = r_chk;
            end
            default: begin
                n_chk = r_chk;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_pool      <= POOL_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (i_cfg_valid && o_cfg_ready) begin
                r_pool <= i_cfg_pool_slots;
            end
            if (r_state == S_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_chk      <= n_chk;
        r_last     <= n_last;
        r_bit      <= n_bit;
        r_status   <= n_status;
        r_slot_off <= n_slot_off;
        if (r_state == S_DONE && out_free) begin
            r_out.status          <= r_status;
            r_out.slot_offset     <= r_slot_off;
            r_out.available_bytes <= avail;
        end
    end

    `BSA_ASSERT_NEXT(a_alloc_count, mem_we && r_state == S_SCAN,
        r_count == $past(r_count) + POOL_W'(1), "grant did not bump the count")
    `BSA_ASSERT_NEXT(a_free_count, mem_we && r_state == S_FREE,
        r_count == $past(r_count) - POOL_W'(1), "release did not drop the count")
    `BSA_ASSERT_NEXT(a_bad_size, in_fire && i_in.action == ACT_ALLOC && i_in.request_size == '0,
        r_state == S_DONE && r_status == STS_BAD_SIZE, "zero-size allocate not rejected")
    `BSA_ASSERT_SAME(a_out_from_done, $rose(o_out_valid),
        $past(r_state == S_DONE), "response beat raised outside the done state")

endmodule
